@@ sv/feal8_pkg.sv @@
// shared constants and round functions of the feal-8 cipher core
package feal8_pkg;

  localparam int unsigned FEAL_ROUNDS = 8;
  localparam int unsigned BLOCK_W     = 64;
  localparam int unsigned HALF_W      = 32;
  localparam int unsigned SUBKEY_W    = 16;

  typedef logic [HALF_W-1:0]   half_t;
  typedef logic [SUBKEY_W-1:0] subkey_t;

  function automatic logic [7:0] rot2(input logic [7:0] x);
    return {x[5:0], x[7:6]};
  endfunction

  function automatic logic [7:0] sbox0(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] s;
    s = x + y;
    return rot2(s);
  endfunction

  function automatic logic [7:0] sbox1(input logic [7:0] x, input logic [7:0] y);
    logic [7:0] s;
    s = x + y + 8'd1;
    return rot2(s);
  endfunction

  // round function f
  function automatic half_t f_fn(input half_t a, input subkey_t k);
    logic [7:0] t0, t1, t2, t3;
    t1 = a[23:16] ^ k[15:8] ^ a[31:24];
    t2 = a[15:8] ^ k[7:0] ^ a[7:0];
    t1 = sbox1(t1, t2);
    t2 = sbox0(t2, t1);
    t0 = sbox0(a[31:24], t1);
    t3 = sbox1(a[7:0], t2);
    return {t0, t1, t2, t3};
  endfunction

  // key schedule function fk
  function automatic half_t fk_fn(input half_t a, input half_t b);
    logic [7:0] t0, t1, t2, t3;
    t1 = a[23:16] ^ a[31:24];
    t2 = a[15:8] ^ a[7:0];
    t1 = sbox1(t1, t2 ^ b[31:24]);
    t2 = sbox0(t2, t1 ^ b[23:16]);
    t0 = sbox0(a[31:24], t1 ^ b[15:8]);
    t3 = sbox1(a[7:0], t2 ^ b[7:0]);
    return {t0, t1, t2, t3};
  endfunction

endpackage

@@ sv/feal8_key_sched.sv @@
// key schedule sequencer: one fk step per cycle, holds the round keys
module feal8_key_sched import feal8_pkg::*; #(
  parameter int unsigned ROUNDS = FEAL_ROUNDS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   key_we_i,
  input  logic [2*HALF_W-1:0]    key_i,
  output logic                   busy_o,
  output subkey_t                round_keys_o [2*((ROUNDS+9)/2)]
);

  localparam int unsigned Iters = (ROUNDS + 9) / 2;
  localparam int unsigned NKeys = 2 * Iters;
  localparam int unsigned CntW  = $clog2(Iters);

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  half_t           a_q, b_q, d_q;
  half_t           nb;
  subkey_t         rk_q [NKeys];

  assign nb = fk_fn(a_q, b_q ^ d_q);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (key_we_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(Iters - 1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      d_q    <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (key_we_i) begin
        a_q <= key_i[2*HALF_W-1:HALF_W];
        b_q <= key_i[HALF_W-1:0];
        d_q <= '0;
      end else if (busy_q) begin
        d_q <= a_q;
        a_q <= b_q;
        b_q <= nb;
      end
    end
  end

  for (genvar j = 0; j < NKeys; j++) begin : g_rk
    localparam int unsigned Step = j / 2;
    localparam bit          Upper = (j % 2) == 0;
    always_ff @(posedge clk_i) begin
      if (busy_q && !key_we_i && cnt_q == CntW'(Step)) begin
        rk_q[j] <= Upper ? nb[HALF_W-1:SUBKEY_W] : nb[SUBKEY_W-1:0];
      end
    end
    assign round_keys_o[j] = rk_q[j];
  end

  assign busy_o = busy_q;

endmodule

@@ sv/feal8_block_cipher_core.sv @@
// top level of the feal-8 ecb cipher core, one round per pipeline stage
//
// blocks enter on the s_axis channel: tdata carries the 64-bit block (left half
// in the upper 32 bits, big-endian bytes), tuser carries func (0 encrypt,
// 1 decrypt). results leave on m_axis as the 64-bit block in tdata.
// the key is written through cfg_wr_en_i / cfg_wr_data_i; the user must write
// it only while the core is idle. the core itself does not enforce this.
// each key write, and reset (which loads the all-zero key), starts a key
// expansion, one fk step per cycle; s_axis_tready stays low until it is done.
// the pipeline has one whitening stage, one stage per round and one output
// stage. throughput is one transfer per cycle unless a key expansion or the
// receiver holds it; encrypt and decrypt may be mixed freely.
// when the receiver holds m_axis_tready low with a result waiting, the whole
// pipeline holds and s_axis_tready drops; nothing is lost or repeated.
module feal8_block_cipher_core import feal8_pkg::*; #(
  parameter int unsigned ROUNDS = FEAL_ROUNDS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [63:0]        cfg_wr_data_i,  // cipher_key
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [BLOCK_W-1:0] s_axis_tdata,   // data_block
  input  logic               s_axis_tuser,   // func
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [BLOCK_W-1:0] m_axis_tdata    // result_block
);

  localparam int unsigned NKeys = 2 * ((ROUNDS + 9) / 2);

  subkey_t     rk [NKeys];
  logic        busy;
  logic        adv;
  half_t       k_enc_pre1, k_enc_pre2, k_dec_pre1, k_dec_pre2;
  half_t       p1, p2, q1, q2;
  half_t       x_in;

  logic        vld_q  [ROUNDS+1];
  logic        func_q [ROUNDS+1];
  half_t       x_q    [ROUNDS+1];
  half_t       y_q    [ROUNDS+1];
  logic        out_vld_q;
  logic [BLOCK_W-1:0] out_q;

  feal8_key_sched #(
    .ROUNDS (ROUNDS)
  ) u_key_sched (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_we_i     (cfg_wr_en_i),
    .key_i        (cfg_wr_data_i),
    .busy_o       (busy),
    .round_keys_o (rk)
  );

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = adv && !busy;

  // whitening key words
  assign k_enc_pre1 = {rk[ROUNDS],   rk[ROUNDS+1]};
  assign k_enc_pre2 = {rk[ROUNDS+2], rk[ROUNDS+3]};
  assign k_dec_pre1 = {rk[ROUNDS+4], rk[ROUNDS+5]};
  assign k_dec_pre2 = {rk[ROUNDS+6], rk[ROUNDS+7]};

  assign p1 = s_axis_tuser ? k_dec_pre1 : k_enc_pre1;
  assign p2 = s_axis_tuser ? k_dec_pre2 : k_enc_pre2;
  assign q1 = func_q[ROUNDS] ? k_enc_pre1 : k_dec_pre1;
  assign q2 = func_q[ROUNDS] ? k_enc_pre2 : k_dec_pre2;

  assign x_in = s_axis_tdata[BLOCK_W-1:HALF_W] ^ p1;

  // input whitening stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      func_q[0] <= s_axis_tuser;
      x_q[0]    <= x_in;
      y_q[0]    <= s_axis_tdata[HALF_W-1:0] ^ p2 ^ x_in;
    end
  end

  // round stages
  for (genvar i = 0; i < ROUNDS; i++) begin : g_round
    localparam int unsigned EncIdx = i;
    localparam int unsigned DecIdx = ROUNDS - 1 - i;
    subkey_t k;
    assign k = func_q[i] ? rk[DecIdx] : rk[EncIdx];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (adv) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        func_q[i+1] <= func_q[i];
        x_q[i+1]    <= y_q[i];
        y_q[i+1]    <= x_q[i] ^ f_fn(y_q[i], k);
      end
    end
  end

  // output whitening stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= vld_q[ROUNDS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= {y_q[ROUNDS] ^ q1, x_q[ROUNDS] ^ y_q[ROUNDS] ^ q2};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ tb/feal8_checker.sv @@
// in-order scoreboard for the feal-8 core: predicts every block result and compares it
module feal8_checker import feal8_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [63:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  output int          mismatch_cnt_o,
  output int          pending_o,
  output int          checked_o
);

  localparam int unsigned NR      = FEAL_ROUNDS;
  localparam int unsigned SCHED_N = (NR + 9) / 2;

  subkey_t     subkeys [2*SCHED_N];
  logic [63:0] result_q [$];
  logic [63:0] want;
  int          mismatches = 0;
  int          checked    = 0;
  int          pending    = 0;

  assign mismatch_cnt_o = mismatches;
  assign checked_o      = checked;
  assign pending_o      = pending;

  // add two bytes (plus carry-in), then rotate left by two
  function automatic logic [7:0] add_rot(input logic [7:0] x, input logic [7:0] y,
                                         input logic cin);
    logic [7:0] sum;
    sum = x + y + {7'd0, cin};
    return {sum[5:0], sum[7:6]};
  endfunction

  function automatic half_t round_mix(input half_t a, input subkey_t k);
    logic [7:0] m0, m1, m2, m3;
    m1 = a[23:16] ^ k[15:8] ^ a[31:24];
    m2 = a[15:8] ^ k[7:0] ^ a[7:0];
    m1 = add_rot(m1, m2, 1'b1);
    m2 = add_rot(m2, m1, 1'b0);
    m0 = add_rot(a[31:24], m1, 1'b0);
    m3 = add_rot(a[7:0], m2, 1'b1);
    return {m0, m1, m2, m3};
  endfunction

  function automatic half_t key_mix(input half_t a, input half_t b);
    logic [7:0] m0, m1, m2, m3;
    m1 = a[23:16] ^ a[31:24];
    m2 = a[15:8] ^ a[7:0];
    m1 = add_rot(m1, m2 ^ b[31:24], 1'b1);
    m2 = add_rot(m2, m1 ^ b[23:16], 1'b0);
    m0 = add_rot(a[31:24], m1 ^ b[15:8], 1'b0);
    m3 = add_rot(a[7:0], m2 ^ b[7:0], 1'b1);
    return {m0, m1, m2, m3};
  endfunction

  function automatic void expand_subkeys(input logic [63:0] key);
    half_t ka, kb, kd, kn;
    ka = key[63:32];
    kb = key[31:0];
    kd = '0;
    for (int i = 0; i < SCHED_N; i++) begin
      kn = key_mix(ka, kb ^ kd);
      kd = ka;
      ka = kb;
      kb = kn;
      subkeys[2*i]   = kn[31:16];
      subkeys[2*i+1] = kn[15:0];
    end
  endfunction

  function automatic half_t subkey_pair(input int idx);
    return {subkeys[idx], subkeys[idx+1]};
  endfunction

  function automatic logic [63:0] encipher(input logic [63:0] blk);
    half_t lh, rh, tmp;
    lh = blk[63:32] ^ subkey_pair(NR);
    rh = blk[31:0] ^ subkey_pair(NR + 2);
    rh = rh ^ lh;
    for (int i = 0; i < NR; i++) begin
      tmp = lh ^ round_mix(rh, subkeys[i]);
      lh  = rh;
      rh  = tmp;
    end
    lh = lh ^ rh;
    rh = rh ^ subkey_pair(NR + 4);
    lh = lh ^ subkey_pair(NR + 6);
    return {rh, lh};
  endfunction

  function automatic logic [63:0] decipher(input logic [63:0] blk);
    half_t lh, rh, tmp;
    rh = blk[63:32] ^ subkey_pair(NR + 4);
    lh = blk[31:0] ^ subkey_pair(NR + 6);
    lh = lh ^ rh;
    for (int i = NR; i > 0; i--) begin
      tmp = rh ^ round_mix(lh, subkeys[i-1]);
      rh  = lh;
      lh  = tmp;
    end
    rh = rh ^ lh;
    lh = lh ^ subkey_pair(NR);
    rh = rh ^ subkey_pair(NR + 2);
    return {lh, rh};
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] exp_blk,
                                 input logic [63:0] got_blk);
    $display("mismatch at %0t: %s, result_block expected %h got %h",
             $realtime, what, exp_blk, got_blk);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_q.delete();
      expand_subkeys(64'd0);
    end else begin
      if (cfg_wr_en_i) expand_subkeys(cfg_wr_data_i);
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(s_axis_tuser ? decipher(s_axis_tdata) : encipher(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          report_mismatch("transfer with no block outstanding", 'x, m_axis_tdata);
        end else begin
          want = result_q.pop_front();
          checked++;
          if (m_axis_tdata !== want) report_mismatch("wrong block", want, m_axis_tdata);
        end
      end
    end
    pending = result_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// top of the feal-8 core testbench: clock, reset, key loads, block stimulus and verdict
module testbench;
  import feal8_pkg::*;

  localparam int unsigned LATENCY     = FEAL_ROUNDS + 2;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASES      = 8;
  localparam int unsigned PHASE_ITEMS = 144;

  typedef enum logic { FUNC_ENC = 1'b0, FUNC_DEC = 1'b1 } func_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_wr_en_i   = 1'b0;
  logic [63:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  int mismatches;
  int pending;
  int checked;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int blocks_sent    = 0;
  int key_loads      = 0;
  int cycle_cnt      = 0;
  int drain_cnt;

  feal8_block_cipher_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  feal8_checker u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(negedge clk_i) m_axis_tready = ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d blocks outstanding", cycle_cnt, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
      default: begin send_idle_pct = 16; recv_stall_pct = 16; end
    endcase
  endtask

  task automatic send_block(input logic [63:0] blk, input func_e op);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      s_axis_tdata  = {$urandom, $urandom};
      s_axis_tuser  = 1'($urandom_range(1));
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = blk;
    s_axis_tuser  = op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    blocks_sent++;
  endtask

  // key writes only with the pipeline drained
  task automatic load_key(input logic [63:0] key);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY) @(negedge clk_i);
    cfg_wr_en_i   = 1'b1;
    cfg_wr_data_i = key;
    @(negedge clk_i);
    cfg_wr_en_i   = 1'b0;
    key_loads++;
  endtask

  function automatic logic [63:0] pick_block();
    logic [63:0] blk;
    blk = {$urandom, $urandom};
    case ($urandom_range(9))
      0: blk[63:32] = '0;
      1: blk[31:0]  = '1;
      2: blk = 64'd1 << $urandom_range(63);
      3: blk = ~(64'd1 << $urandom_range(63));
      default: ;
    endcase
    return blk;
  endfunction

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset key is all zero
    set_idling(0);
    send_block(64'h0000000000000000, FUNC_ENC);
    send_block(64'h0000000000000000, FUNC_DEC);
    send_block(64'hFFFFFFFFFFFFFFFF, FUNC_ENC);
    send_block(64'hFFFFFFFFFFFFFFFF, FUNC_DEC);
    send_block(64'h8000000000000000, FUNC_ENC);
    send_block(64'h0000000000000001, FUNC_DEC);
    send_block(64'hAAAAAAAA55555555, FUNC_ENC);
    send_block(64'h00000000FFFFFFFF, FUNC_DEC);
    send_block(64'hFFFFFFFF00000000, FUNC_ENC);
    send_block(64'h0123456789ABCDEF, FUNC_ENC);
    send_block(64'h0123456789ABCDEF, FUNC_DEC);

    // published test key and its known ciphertext
    load_key(64'h0123456789ABCDEF);
    send_block(64'h0000000000000000, FUNC_ENC);
    send_block(64'hCEEF2C86F2490752, FUNC_DEC);
    send_block(64'hFFFFFFFFFFFFFFFF, FUNC_DEC);

    load_key(64'hFFFFFFFFFFFFFFFF);
    send_block(64'h0000000000000000, FUNC_ENC);
    send_block(64'hFFFFFFFFFFFFFFFF, FUNC_DEC);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_key(64'hFFFFFFFFFFFFFFFF);
        1: load_key(64'h0000000000000000);
        3: load_key(64'h8000000000000001);
        default: load_key({$urandom, $urandom});
      endcase
      set_idling(ph % 4);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_block(pick_block(), func_e'($urandom_range(1)));
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    drain_cnt = 0;
    while (pending != 0 && drain_cnt < 50000) begin
      @(negedge clk_i);
      drain_cnt++;
    end
    repeat (LATENCY + 4) @(negedge clk_i);

    $display("ran %0d blocks (encrypt and decrypt mixed) under %0d keys", blocks_sent,
             key_loads + 1);
    $display("%0d results compared, %0d mismatches, idle and stall phases included",
             checked, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      if (pending != 0) $display("%0d blocks never came back", pending);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
